/* src/prtq_pkg.sv */
package prtq_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned NUM_AX  = 3;

    // u = 2 (v x p) keeps 36 bits; it is split into a signed high part and
    // an unsigned 16-bit low part so every multiply by u stays near 32x20
    localparam int unsigned U_W     = 36;
    localparam int unsigned UH_W    = 20;
    localparam int unsigned UL_W    = 16;
    localparam int unsigned P1_W    = 64;
    localparam int unsigned D1_W    = 65;
    localparam int unsigned PH_W    = 52;
    localparam int unsigned PL_W    = 49;
    localparam int unsigned WF_W    = 68;
    localparam int unsigned CF_W    = 69;
    localparam int unsigned WU_W    = 38;
    localparam int unsigned CU_W    = 39;
    localparam int unsigned SUM_W   = 41;

    typedef enum logic [IDX_W-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } reg_idx_t;

    localparam logic signed [CFG_W-1:0] ROT_W_RESET = 32'sh4000_0000;

    // axis rotation for cross products: component i uses axes i+1 and i+2
    typedef int unsigned axis_map_t [NUM_AX];
    localparam axis_map_t NEXT_AX = '{1, 2, 0};
    localparam axis_map_t PREV_AX = '{2, 0, 1};

    localparam logic signed [SUM_W-1:0] SAT_MAX = 41'sh000_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -41'sh000_8000_0000;

endpackage

/* src/point_rigid_transform_quaternion.sv */
// Throughput: one point per cycle while m_tready does not stall; five register
// stages (a 32x32 multiply, a subtract, a multiply by the split halves of u,
// a recombine, then the sum).
// Backpressure on m_tready stalls all stages together; nothing is dropped.
// Reset: rst_n (async, active low) empties the pipeline and loads the
// identity pose (rot_w = 1.0, all other registers zero).
module point_rigid_transform_quaternion (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic [31:0] s_tuser,   // tag [31:0]
    // transformed points
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [31:0] m_tuser    // out_tag [31:0]
);
    import prtq_pkg::*;

    localparam int unsigned NSTG = 5;

    logic signed [CFG_W-1:0] rot_w_reg;
    logic signed [CFG_W-1:0] rot_v_reg   [NUM_AX];
    logic signed [CFG_W-1:0] shift_reg   [NUM_AX];

    logic [NSTG-1:0] vld_reg;
    logic            advance;

    // payload carried along with each stage
    logic signed [COORD_W-1:0] pos_reg   [NSTG-1][NUM_AX];
    logic [TAG_W-1:0]          tag_reg   [NSTG-1];

    logic signed [P1_W-1:0]    pa_reg    [NUM_AX];
    logic signed [P1_W-1:0]    pb_reg    [NUM_AX];
    logic signed [U_W-1:0]     u_reg     [NUM_AX];
    logic signed [PH_W-1:0]    wh_reg    [NUM_AX];
    logic signed [PL_W-1:0]    wl_reg    [NUM_AX];
    logic signed [PH_W-1:0]    cha_reg   [NUM_AX];
    logic signed [PH_W-1:0]    chb_reg   [NUM_AX];
    logic signed [PL_W-1:0]    cla_reg   [NUM_AX];
    logic signed [PL_W-1:0]    clb_reg   [NUM_AX];
    logic signed [WU_W-1:0]    wu_reg    [NUM_AX];
    logic signed [CU_W-1:0]    cu_reg    [NUM_AX];
    logic signed [COORD_W-1:0] res_reg   [NUM_AX];
    logic [TAG_W-1:0]          res_tag_reg;

    logic signed [COORD_W-1:0] pos_in    [NUM_AX];
    logic signed [P1_W-1:0]    pa_next   [NUM_AX];
    logic signed [P1_W-1:0]    pb_next   [NUM_AX];
    logic signed [U_W-1:0]     u_next    [NUM_AX];
    logic signed [UH_W-1:0]    uh        [NUM_AX];
    logic signed [UL_W:0]      ul        [NUM_AX];
    logic signed [PH_W-1:0]    wh_next   [NUM_AX];
    logic signed [PL_W-1:0]    wl_next   [NUM_AX];
    logic signed [PH_W-1:0]    cha_next  [NUM_AX];
    logic signed [PH_W-1:0]    chb_next  [NUM_AX];
    logic signed [PL_W-1:0]    cla_next  [NUM_AX];
    logic signed [PL_W-1:0]    clb_next  [NUM_AX];
    logic signed [WU_W-1:0]    wu_next   [NUM_AX];
    logic signed [CU_W-1:0]    cu_next   [NUM_AX];
    logic signed [COORD_W-1:0] res_next  [NUM_AX];

    assign advance  = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {res_reg[2], res_reg[1], res_reg[0]};
    assign m_tuser  = res_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_w_reg <= ROT_W_RESET;
            for (int i = 0; i < NUM_AX; i++)
            begin
                rot_v_reg[i] <= '0;
                shift_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_W:   rot_w_reg    <= cfg_wdata;
                REG_ROT_X:   rot_v_reg[0] <= cfg_wdata;
                REG_ROT_Y:   rot_v_reg[1] <= cfg_wdata;
                REG_ROT_Z:   rot_v_reg[2] <= cfg_wdata;
                REG_SHIFT_X: shift_reg[0] <= cfg_wdata;
                REG_SHIFT_Y: shift_reg[1] <= cfg_wdata;
                REG_SHIFT_Z: shift_reg[2] <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // stage 1: v x p partial products
    always_comb
    begin
        pos_in[0] = s_tdata[31:0];
        pos_in[1] = s_tdata[63:32];
        pos_in[2] = s_tdata[95:64];
        for (int i = 0; i < NUM_AX; i++)
        begin
            pa_next[i] = rot_v_reg[NEXT_AX[i]] * pos_in[PREV_AX[i]];
            pb_next[i] = rot_v_reg[PREV_AX[i]] * pos_in[NEXT_AX[i]];
        end
    end

    // stage 2: u = floor((a - b) / 2^29)
    always_comb
    begin
        logic signed [D1_W-1:0] d;
        for (int i = 0; i < NUM_AX; i++)
        begin
            d         = D1_W'(pa_reg[i]) - D1_W'(pb_reg[i]);
            u_next[i] = d[D1_W-1:29];
        end
    end

    // stage 3: w*u and v x u, each operand u split into high and low parts
    always_comb
    begin
        for (int i = 0; i < NUM_AX; i++)
        begin
            uh[i] = u_reg[i][U_W-1:UL_W];
            ul[i] = $signed({1'b0, u_reg[i][UL_W-1:0]});
        end
        for (int i = 0; i < NUM_AX; i++)
        begin
            wh_next[i]  = rot_w_reg * uh[i];
            wl_next[i]  = rot_w_reg * ul[i];
            cha_next[i] = rot_v_reg[NEXT_AX[i]] * uh[PREV_AX[i]];
            chb_next[i] = rot_v_reg[PREV_AX[i]] * uh[NEXT_AX[i]];
            cla_next[i] = rot_v_reg[NEXT_AX[i]] * ul[PREV_AX[i]];
            clb_next[i] = rot_v_reg[PREV_AX[i]] * ul[NEXT_AX[i]];
        end
    end

    // stage 4: recombine the halves and floor each term by 2^30
    always_comb
    begin
        logic signed [WF_W-1:0] wf;
        logic signed [CF_W-1:0] cf;
        for (int i = 0; i < NUM_AX; i++)
        begin
            wf = (WF_W'(wh_reg[i]) <<< UL_W) + WF_W'(wl_reg[i]);
            cf = ((CF_W'(cha_reg[i]) - CF_W'(chb_reg[i])) <<< UL_W)
               + (CF_W'(cla_reg[i]) - CF_W'(clb_reg[i]));
            wu_next[i] = wf[WF_W-1:30];
            cu_next[i] = cf[CF_W-1:30];
        end
    end

    // stage 5: p + w*u + v x u + t, saturated
    always_comb
    begin
        logic signed [SUM_W-1:0] s;
        for (int i = 0; i < NUM_AX; i++)
        begin
            s = SUM_W'(pos_reg[3][i]) + SUM_W'(wu_reg[i]) + SUM_W'(cu_reg[i])
              + SUM_W'(shift_reg[i]);
            priority if (s > SAT_MAX)
                res_next[i] = SAT_MAX[COORD_W-1:0];
            else if (s < SAT_MIN)
                res_next[i] = SAT_MIN[COORD_W-1:0];
            else
                res_next[i] = s[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NUM_AX; i++)
            begin
                pos_reg[0][i] <= pos_in[i];
                pa_reg[i]     <= pa_next[i];
                pb_reg[i]     <= pb_next[i];
                u_reg[i]      <= u_next[i];
                wh_reg[i]     <= wh_next[i];
                wl_reg[i]     <= wl_next[i];
                cha_reg[i]    <= cha_next[i];
                chb_reg[i]    <= chb_next[i];
                cla_reg[i]    <= cla_next[i];
                clb_reg[i]    <= clb_next[i];
                wu_reg[i]     <= wu_next[i];
                cu_reg[i]     <= cu_next[i];
                res_reg[i]    <= res_next[i];
            end
            for (int k = 1; k < NSTG - 1; k++)
            begin
                pos_reg[k] <= pos_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
            tag_reg[0]  <= s_tuser;
            res_tag_reg <= tag_reg[NSTG-2];
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import prtq_pkg::*;

    localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] I32_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] NEG_ONE_Q30 = 32'hC000_0000;
    localparam logic [31:0] HALF_SQRT2_Q30 = 32'h2D41_3CCD;
    // index past the last register; writes to it must be ignored
    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int NUM_REGS = 7;
    localparam int PHASES = 10;
    localparam int POINTS_PER_PHASE = 50;
    localparam int LONG_HOLD = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED = 50;

    localparam logic signed [127:0] COORD_MAX = 128'sd2147483647;
    localparam logic signed [127:0] COORD_MIN = -128'sd2147483648;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    typedef enum {DO_WRITE, DO_POINT, DO_POINT_KNOWN} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic [2:0]  idx;
        logic [31:0] val;
        logic [31:0] x, y, z, tag;
        logic [31:0] want_x, want_y, want_z;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [31:0] s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [31:0] m_tuser;

    logic [31:0] pose [NUM_REGS];
    point_t      pending_points [$];
    int          mismatches = 0;
    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    bit          long_hold = 1'b0;

    step_t plan [$] = '{
        // identity pose after reset: points pass through untouched
        '{DO_POINT_KNOWN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_POINT_KNOWN, 0, 0, I32_MAX, I32_MAX, I32_MAX, 32'hFFFF_FFFF,
          I32_MAX, I32_MAX, I32_MAX},
        '{DO_POINT_KNOWN, 0, 0, I32_MIN, I32_MIN, I32_MIN, 32'hAAAA_AAAA,
          I32_MIN, I32_MIN, I32_MIN},
        '{DO_POINT_KNOWN, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
          32'h5555_5555, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678},
        // translation only: saturate at both bounds
        '{DO_WRITE, REG_SHIFT_X, I32_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_SHIFT_Y, I32_MIN, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_SHIFT_Z, 32'd1, 0, 0, 0, 0, 0, 0, 0},
        '{DO_POINT_KNOWN, 0, 0, I32_MAX, I32_MIN, 0, 32'd1, I32_MAX, I32_MIN, 32'd1},
        '{DO_POINT_KNOWN, 0, 0, I32_MIN, I32_MAX, I32_MAX, 32'd2,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, I32_MAX},
        '{DO_WRITE, REG_NONE, I32_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{DO_POINT_KNOWN, 0, 0, 0, 0, 0, 32'd3, I32_MAX, I32_MIN, 32'd1},
        // half turn about z
        '{DO_WRITE, REG_SHIFT_X, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_SHIFT_Y, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_SHIFT_Z, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_W, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_Z, ONE_Q30, 0, 0, 0, 0, 0, 0, 0},
        '{DO_POINT, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd4, 0, 0, 0},
        '{DO_POINT, 0, 0, I32_MAX, I32_MIN, I32_MAX, 32'd5, 0, 0, 0},
        // non-unit quaternion at the register extremes
        '{DO_WRITE, REG_ROT_W, I32_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_X, I32_MIN, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_Y, I32_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_Z, I32_MIN, 0, 0, 0, 0, 0, 0, 0},
        '{DO_POINT, 0, 0, I32_MAX, I32_MAX, I32_MAX, 32'd6, 0, 0, 0},
        '{DO_POINT, 0, 0, I32_MIN, I32_MAX, 0, 32'd7, 0, 0, 0},
        '{DO_POINT, 0, 0, 32'd1, 32'hFFFF_FFFF, I32_MIN, 32'd8, 0, 0, 0},
        // quarter turn about x with a small shift
        '{DO_WRITE, REG_ROT_W, HALF_SQRT2_Q30, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_X, HALF_SQRT2_Q30, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_Y, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_Z, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_SHIFT_X, 32'h0001_8000, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_SHIFT_Y, 32'hFFFE_8000, 0, 0, 0, 0, 0, 0, 0},
        '{DO_POINT, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd9, 0, 0, 0},
        '{DO_POINT, 0, 0, 32'hFFFF_8000, 32'h7FFF_0000, 32'h1234_5678, 32'd10, 0, 0, 0},
        // zero quaternion leaves only the translation
        '{DO_WRITE, REG_ROT_W, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_WRITE, REG_ROT_X, 0, 0, 0, 0, 0, 0, 0, 0},
        '{DO_POINT, 0, 0, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'd11, 0, 0, 0}
    };

    point_rigid_transform_quaternion dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    // floor((a1*b1 - a2*b2) / 2^sh), exact in wide signed arithmetic
    function automatic logic signed [127:0] floor_diff(
        input logic signed [127:0] a1, b1, a2, b2,
        input int sh
    );
        logic signed [127:0] d;
        d = a1 * b1 - a2 * b2;
        return d >>> sh;
    endfunction

    function automatic logic [31:0] clamp_coord(input logic signed [127:0] v);
        if (v > COORD_MAX)
            return I32_MAX;
        else if (v < COORD_MIN)
            return I32_MIN;
        return v[31:0];
    endfunction

    function automatic point_t transform_point(input point_t p);
        logic signed [127:0] w, vx, vy, vz, px, py, pz, ux, uy, uz;
        point_t r;
        w  = $signed(pose[REG_ROT_W]);
        vx = $signed(pose[REG_ROT_X]);
        vy = $signed(pose[REG_ROT_Y]);
        vz = $signed(pose[REG_ROT_Z]);
        px = $signed(p.x);
        py = $signed(p.y);
        pz = $signed(p.z);
        // u = 2 (v x p), kept unsaturated
        ux = floor_diff(vy, pz, vz, py, 29);
        uy = floor_diff(vz, px, vx, pz, 29);
        uz = floor_diff(vx, py, vy, px, 29);
        r.x = clamp_coord(px + floor_diff(w, ux, 0, 0, 30)
                          + floor_diff(vy, uz, vz, uy, 30)
                          + $signed(pose[REG_SHIFT_X]));
        r.y = clamp_coord(py + floor_diff(w, uy, 0, 0, 30)
                          + floor_diff(vz, ux, vx, uz, 30)
                          + $signed(pose[REG_SHIFT_Y]));
        r.z = clamp_coord(pz + floor_diff(w, uz, 0, 0, 30)
                          + floor_diff(vx, uy, vy, ux, 30)
                          + $signed(pose[REG_SHIFT_Z]));
        r.tag = p.tag;
        return r;
    endfunction

    function automatic logic [31:0] random_coord(input int shape);
        logic [31:0] pick [5];
        pick = '{I32_MAX, I32_MIN, 32'd0, 32'd1, 32'hFFFF_FFFF};
        case (shape)
            0: return $urandom;
            1: return $urandom_range(0, 2**21) - 2**20;
            default: return pick[$urandom_range(0, 4)];
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    // leaves cfg_we high so back-to-back writes need no gap
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx < NUM_REGS)
            pose[idx] = val;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_point(input point_t p, input bit known, input point_t want);
        int gap;
        cfg_we <= 1'b0;
        gap = send_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.z, p.y, p.x};
        s_tuser  <= p.tag;
        do
            @(posedge clk);
        while (!s_tready);
        pending_points.insert(pending_points.size(), known ? want : transform_point(p));
    endtask

    initial
    begin
        point_t p, want;
        int shape, cfg_mode;
        logic [31:0] extremes [5];

        extremes = '{I32_MAX, I32_MIN, 32'd0, ONE_Q30, NEG_ONE_Q30};
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        foreach (pose[i])
            pose[i] = 32'd0;
        pose[REG_ROT_W] = ONE_Q30;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == DO_WRITE)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                p    = '{tag: plan[i].tag, z: plan[i].z, y: plan[i].y, x: plan[i].x};
                want = '{tag: plan[i].tag, z: plan[i].want_z, y: plan[i].want_y,
                         x: plan[i].want_x};
                send_point(p, plan[i].kind == DO_POINT_KNOWN, want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            // early phases run with no idling, the pressure phase floods the input
            send_gaps = (ph >= 2) && (ph != 3) && ($urandom_range(0, 3) != 0);
            recv_gaps = (ph >= 2) && ($urandom_range(0, 3) != 0);
            long_hold = (ph == 3);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_NONE, $urandom);
            cfg_mode = $urandom_range(0, 3);
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case (cfg_mode)
                    0: write_reg(3'(r), $urandom);
                    1: write_reg(3'(r), (r < 4) ? $urandom_range(0, 2**30) - 2**29
                                                : $urandom_range(0, 2**22) - 2**21);
                    2: write_reg(3'(r), extremes[$urandom_range(0, 4)]);
                    default: write_reg(3'(r), (r == REG_ROT_W) ? ONE_Q30
                                              : (r < 4) ? 32'd0 : $urandom);
                endcase
            end
            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                shape = $urandom_range(0, 5);
                p.x   = random_coord(shape % 3);
                p.y   = random_coord(shape % 3);
                p.z   = random_coord((shape > 3) ? 2 : shape % 3);
                p.tag = $urandom;
                send_point(p, 1'b0, p);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        int stall;
        point_t want;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = recv_gaps ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (pending_points.size() == 0)
                report_mismatch($sformatf("unexpected point %h tag %h", m_tdata, m_tuser));
            else
            begin
                want = pending_points.pop_front();
                if (m_tdata[31:0] !== want.x)
                    report_mismatch($sformatf("out_x got %h want %h", m_tdata[31:0], want.x));
                if (m_tdata[63:32] !== want.y)
                    report_mismatch($sformatf("out_y got %h want %h", m_tdata[63:32], want.y));
                if (m_tdata[95:64] !== want.z)
                    report_mismatch($sformatf("out_z got %h want %h", m_tdata[95:64], want.z));
                if (m_tuser !== want.tag)
                    report_mismatch($sformatf("out_tag got %h want %h", m_tuser, want.tag));
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
